>>> rtl/core/grc_pkg.sv
// Shared types and constants of the column raycaster.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package grc_pkg;

  // Default geometry
  localparam int SCREEN_W_DEF  = 320;
  localparam int SCREEN_H_DEF  = 240;
  localparam int MAP_DIM_DEF   = 64;
  localparam int MAX_STEPS_DEF = 128;

  // Datapath widths, sized for the whole legal parameter range
  localparam int DIV_W   = 34;  // dividend and quotient
  localparam int DVS_W   = 52;  // divisor
  localparam int CAM_W   = 25;  // camera offset, signed Q.16
  localparam int PROD_W  = 44;  // plane * camera offset
  localparam int RAY_W   = 30;  // ray component, signed Q.16
  localparam int DELTA_W = 41;  // step distance, 2^40 marks no step
  localparam int SD_W    = 52;  // accumulated side distance
  localparam int CELL_W  = 25;  // solid flag and RGB

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_POS_X   = 3'd0,
    REG_POS_Y   = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_PLANE_X = 3'd4,
    REG_PLANE_Y = 3'd5
  } reg_idx_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [8:0]  column;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [CELL_W-1:0] cell_data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

  typedef struct packed {
    logic        [21:0] pos_x;
    logic        [21:0] pos_y;
    logic signed [18:0] dir_x;
    logic signed [18:0] dir_y;
    logic signed [18:0] plane_x;
    logic signed [18:0] plane_y;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [8:0]  column;
    logic        hit;
    logic [7:0]  wall_top;
    logic [7:0]  wall_bottom;
    logic [31:0] wall_color;
    logic        hit_side;
    logic [23:0] distance;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/grc_front.sv
// Front end: takes commands, drops cell writes outside the map and queues
// the rest for the back end. Depends on grc_pkg.
`default_nettype none

module grc_front #(
  parameter int MAP_DIM = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_func,
  input  wire logic [8:0]         in_column,
  input  wire logic [5:0]         in_cell_x,
  input  wire logic [5:0]         in_cell_y,
  input  wire logic               in_cell_solid,
  input  wire logic [7:0]         in_cell_red,
  input  wire logic [7:0]         in_cell_green,
  input  wire logic [7:0]         in_cell_blue,
  input  wire grc_pkg::back_stat_t stat,
  output grc_pkg::queue_t         q
);
  import grc_pkg::*;

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      it;
  logic       keep, push;

  always_comb begin
    it.op        = in_func ? OP_CAST : OP_WRITE;
    it.column    = in_column;
    it.cell_x    = in_cell_x;
    it.cell_y    = in_cell_y;
    it.cell_data = {in_cell_solid, in_cell_red, in_cell_green, in_cell_blue};
    keep = in_func || ((32'(in_cell_x) < MAP_DIM) && (32'(in_cell_y) < MAP_DIM));
  end

  assign busy   = (cnt_r == 2'd2) || stat.clearing;
  assign push   = start && !busy && keep;
  assign q.valid = (cnt_r != 2'd0);
  assign q.item  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= it;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (stat.pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(stat.pop);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/grc_div.sv
// Restoring divider, one quotient bit per cycle; done pulses in the cycle after
// the last iteration. Depends on grc_pkg.
`default_nettype none

module grc_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [grc_pkg::DIV_W-1:0] dvd,
  input  wire logic [grc_pkg::DVS_W-1:0] dvs,
  output logic                           done,
  output logic [grc_pkg::DIV_W-1:0]      quo
);
  import grc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DVS_W:0]     rem_r;
  logic [DIV_W-1:0]   quo_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               run_r, done_r;
  logic [DVS_W:0]     rem_sh;
  logic               ge;

  always_comb begin
    rem_sh = {rem_r[DVS_W-1:0], quo_r[DIV_W-1]};
    ge     = rem_sh >= {1'b0, dvs_r};
  end

  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dvd;
      dvs_r <= dvs;
      cnt_r <= '0;
    end else if (run_r) begin
      rem_r <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_r <= {quo_r[DIV_W-2:0], ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == CNT_W'(DIV_W - 1))) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/grc_back.sv
// Back end: wall map memory, clearing pass, ray setup, DDA walk and span.
// Depends on grc_pkg and grc_div.
`default_nettype none

module grc_back #(
  parameter int SCREEN_W  = 320,
  parameter int SCREEN_H  = 240,
  parameter int MAP_DIM   = 64,
  parameter int MAX_STEPS = 128
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire grc_pkg::queue_t  q,
  input  wire grc_pkg::cfg_t    cfg,
  output grc_pkg::back_stat_t   stat,
  output grc_pkg::res_t         res
);
  import grc_pkg::*;

  localparam int DEPTH = MAP_DIM * MAP_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int MX_W  = $clog2((MAP_DIM > 64) ? MAP_DIM : 64) + 2;
  localparam int N_W   = $clog2(MAX_STEPS + 1);
  localparam int PR_W  = DELTA_W + 17;
  // column * 2^17 / SCREEN_W by reciprocal multiplication, exact for 9-bit columns
  localparam int     CQ_W   = 40;
  localparam int     CAM_SH = 9 + $clog2(SCREEN_W);
  localparam longint CAM_M  = ((longint'(1) << (26 + $clog2(SCREEN_W))) +
                               longint'(SCREEN_W) - 1) / longint'(SCREEN_W);
  localparam logic [CQ_W-1:0]        CAM_MUL   = CQ_W'(CAM_M);
  localparam logic [AW-1:0]          LAST_ADDR = AW'(DEPTH - 1);
  localparam logic signed [MX_W-1:0] MAP_S     = MX_W'(MAP_DIM);
  localparam logic signed [MX_W-1:0] STEP_P    = MX_W'(1);
  localparam logic signed [MX_W-1:0] STEP_N    = -MX_W'(1);
  localparam logic [DIV_W-1:0]       H_Q16     = DIV_W'(SCREEN_H * 65536);
  localparam logic [DIV_W-1:0]       H_HALF    = DIV_W'(SCREEN_H / 2);
  localparam logic [DIV_W-1:0]       H_LAST    = DIV_W'(SCREEN_H - 1);
  localparam logic [DIV_W-1:0]       H_ROOM    = DIV_W'(SCREEN_H - 1 - SCREEN_H / 2);
  localparam logic [DIV_W-1:0]       ONE_Q32   = DIV_W'(64'd1 << 32);
  localparam logic [DELTA_W-1:0]     D_INF     = DELTA_W'(64'd1 << 40);

  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001,
    S_IDLE  = 15'h0002,
    S_CAMW  = 15'h0004,
    S_RAY   = 15'h0008,
    S_RAY2  = 15'h0010,
    S_DX    = 15'h0020,
    S_DXW   = 15'h0040,
    S_DY    = 15'h0080,
    S_DYW   = 15'h0100,
    S_SIDE  = 15'h0200,
    S_STEP  = 15'h0400,
    S_READ  = 15'h0800,
    S_LINEW = 15'h1000,
    S_FIN   = 15'h2000,
    S_MISS  = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_r, cell_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa, rd_addr, clr_r;
  logic [CELL_W-1:0] mem_wd;

  logic [8:0]               col_r;
  logic signed [CAM_W-1:0]  cam_r;
  logic signed [PROD_W-1:0] prodx_r, prody_r;
  logic signed [RAY_W-1:0]  rx_r, ry_r;
  logic [DELTA_W-1:0]       dx_r, dy_r;
  logic [SD_W-1:0]          sx_r, sy_r, perp_r;
  logic signed [MX_W-1:0]   mx_r, my_r, mx_n, my_n, stx, sty;
  logic [N_W-1:0]           n_r;
  logic                     side_r;
  logic [DIV_W-1:0]         lh_r;
  res_t                     res_r;

  logic             take_x, outside;
  logic [SD_W-1:0]  perp_c;
  logic [16:0]      tx, ty;
  logic [DVS_W-1:0] ax, ay;
  logic [CQ_W-1:0]  cam_prod;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;

  logic [DIV_W-1:0] half, top_w, bot_w;
  logic [7:0]       sr, sg, sb;

  function automatic logic [7:0] shade(input logic [7:0] c);
    logic [17:0] p;
    p = 18'({c, 1'b0}) * 18'd171;
    return p[16:9];
  endfunction

  grc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (div_done),
    .quo   (div_q)
  );

  // Camera product, step selection, neighbor cell and ray setup terms
  always_comb begin
    cam_prod = CQ_W'(col_r) * CAM_MUL;
    stx     = (rx_r < 0) ? STEP_N : ((rx_r != 0) ? STEP_P : '0);
    sty     = (ry_r < 0) ? STEP_N : ((ry_r != 0) ? STEP_P : '0);
    take_x  = sx_r < sy_r;
    mx_n    = take_x ? mx_r + stx : mx_r;
    my_n    = take_x ? my_r : my_r + sty;
    outside = (mx_n < 0) || (my_n < 0) || (mx_n >= MAP_S) || (my_n >= MAP_S);
    rd_addr = AW'(AW'(mx_n) * AW'(MAP_DIM)) + AW'(my_n);
    perp_c  = side_r ? sy_r - SD_W'(dy_r) : sx_r - SD_W'(dx_r);
    ax      = DVS_W'((rx_r < 0) ? -rx_r : rx_r);
    ay      = DVS_W'((ry_r < 0) ? -ry_r : ry_r);
    tx      = (rx_r < 0) ? {1'b0, cfg.pos_x[15:0]} : 17'h10000 - 17'(cfg.pos_x[15:0]);
    ty      = (ry_r < 0) ? {1'b0, cfg.pos_y[15:0]} : 17'h10000 - 17'(cfg.pos_y[15:0]);
  end

  // Span and color of a hit
  always_comb begin
    half  = lh_r >> 1;
    top_w = (half >= H_HALF) ? '0 : H_HALF - half;
    bot_w = (half > H_ROOM) ? H_LAST : H_HALF + half;
    sr    = side_r ? shade(cell_r[23:16]) : cell_r[23:16];
    sg    = side_r ? shade(cell_r[15:8])  : cell_r[15:8];
    sb    = side_r ? shade(cell_r[7:0])   : cell_r[7:0];
  end

  always_comb begin
    state_nxt     = state_r;
    stat.pop      = 1'b0;
    stat.clearing = (state_r == S_CLEAR);
    mem_we        = 1'b0;
    mem_wa        = AW'(AW'(q.item.cell_x) * AW'(MAP_DIM)) + AW'(q.item.cell_y);
    mem_wd        = q.item.cell_data;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q.valid) begin
          stat.pop = 1'b1;
          if (q.item.op == OP_CAST) begin
            state_nxt = S_CAMW;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      S_CAMW:  state_nxt = S_RAY;
      S_RAY:   state_nxt = S_RAY2;
      S_RAY2:  state_nxt = S_DX;
      S_DX: begin
        div_start = 1'b1;
        div_dvd   = ONE_Q32;
        div_dvs   = ax;
        state_nxt = S_DXW;
      end
      S_DXW:   if (div_done) state_nxt = S_DY;
      S_DY: begin
        div_start = 1'b1;
        div_dvd   = ONE_Q32;
        div_dvs   = ay;
        state_nxt = S_DYW;
      end
      S_DYW:   if (div_done) state_nxt = S_SIDE;
      S_SIDE:  state_nxt = S_STEP;
      S_STEP:  state_nxt = outside ? S_MISS : S_READ;
      S_READ: begin
        if (rd_r[CELL_W-1]) begin
          div_start = 1'b1;
          div_dvd   = H_Q16;
          div_dvs   = (perp_c == '0) ? DVS_W'(1) : DVS_W'(perp_c);
          state_nxt = S_LINEW;
        end else if (n_r == N_W'(MAX_STEPS)) begin
          state_nxt = S_MISS;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_LINEW: if (div_done) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      S_MISS:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: col_r <= q.item.column;
      S_CAMW: cam_r <= CAM_W'(cam_prod >> CAM_SH) - CAM_W'(65536);
      S_RAY: begin
        prodx_r <= PROD_W'(cfg.plane_x) * PROD_W'(cam_r);
        prody_r <= PROD_W'(cfg.plane_y) * PROD_W'(cam_r);
      end
      S_RAY2: begin
        rx_r <= RAY_W'(cfg.dir_x) + RAY_W'(prodx_r >>> 16);
        ry_r <= RAY_W'(cfg.dir_y) + RAY_W'(prody_r >>> 16);
      end
      S_DXW: dx_r <= (rx_r == 0) ? D_INF : DELTA_W'(div_q);
      S_DYW: dy_r <= (ry_r == 0) ? D_INF : DELTA_W'(div_q);
      S_SIDE: begin
        sx_r   <= SD_W'((PR_W'(dx_r) * PR_W'(tx)) >> 16);
        sy_r   <= SD_W'((PR_W'(dy_r) * PR_W'(ty)) >> 16);
        mx_r   <= MX_W'(cfg.pos_x[21:16]);
        my_r   <= MX_W'(cfg.pos_y[21:16]);
        n_r    <= '0;
        side_r <= 1'b0;
      end
      S_STEP: begin
        if (take_x) begin
          sx_r <= sx_r + SD_W'(dx_r);
        end else begin
          sy_r <= sy_r + SD_W'(dy_r);
        end
        mx_r   <= mx_n;
        my_r   <= my_n;
        side_r <= !take_x;
        n_r    <= n_r + N_W'(1);
      end
      S_READ: begin
        cell_r <= rd_r;
        perp_r <= perp_c;
      end
      S_LINEW: lh_r <= div_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r.column <= col_r;
    if (state_r == S_FIN) begin
      res_r.hit         <= 1'b1;
      res_r.wall_top    <= top_w[7:0];
      res_r.wall_bottom <= bot_w[7:0];
      res_r.wall_color  <= {8'hFF, sr, sg, sb};
      res_r.hit_side    <= side_r;
      res_r.distance    <= (perp_r > SD_W'(24'hFFFFFF)) ? 24'hFFFFFF : perp_r[23:0];
    end else begin
      res_r.hit         <= 1'b0;
      res_r.wall_top    <= H_HALF[7:0];
      res_r.wall_bottom <= H_HALF[7:0];
      res_r.wall_color  <= '0;
      res_r.hit_side    <= 1'b0;
      res_r.distance    <= 24'hFFFFFF;
    end
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      res_r.valid <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r.valid <= (state_r == S_FIN) || (state_r == S_MISS);
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

>>> rtl/core/grid_raycast_column.sv
// Top level of the column raycaster: configuration registers and the
// front and back ends. Depends on grc_pkg, grc_front and grc_back.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------
//   command  | start / busy          | in_func, in_column, in_cell_*
//   result   | out_valid (strobe)    | out_column ... out_distance
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The back end stores a cell write from its idle state. A cast that hits
// strobes its result after three passes of the one-bit-per-cycle divider
// (dx, dy and line height) and, for each DDA step, a step state and a map
// memory read state; a miss skips the last divide.
// Two commands queue between the front and back end; busy rises when full.
// After reset a clearing pass zeroes all MAP_DIM * MAP_DIM cells of the map;
// busy stays high until it ends. Results cannot be stalled.
`default_nettype none

module grid_raycast_column #(
  parameter int SCREEN_W  = grc_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H  = grc_pkg::SCREEN_H_DEF,
  parameter int MAP_DIM   = grc_pkg::MAP_DIM_DEF,
  parameter int MAX_STEPS = grc_pkg::MAX_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic [8:0]  in_column,
  input  wire logic [5:0]  in_cell_x,
  input  wire logic [5:0]  in_cell_y,
  input  wire logic        in_cell_solid,
  input  wire logic [7:0]  in_cell_red,
  input  wire logic [7:0]  in_cell_green,
  input  wire logic [7:0]  in_cell_blue,
  output logic             out_valid,
  output logic [8:0]       out_column,
  output logic             out_hit,
  output logic [7:0]       out_wall_top,
  output logic [7:0]       out_wall_bottom,
  output logic [31:0]      out_wall_color,
  output logic             out_hit_side,
  output logic [23:0]      out_distance,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [21:0] cfg_data
);
  import grc_pkg::*;

  cfg_t       cfg_r;
  queue_t     q;
  back_stat_t stat;
  res_t       res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_x   <= '0;
      cfg_r.pos_y   <= '0;
      cfg_r.dir_x   <= -19'sd65536;
      cfg_r.dir_y   <= '0;
      cfg_r.plane_x <= '0;
      cfg_r.plane_y <= 19'sd43254;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POS_X:   cfg_r.pos_x   <= cfg_data;
        REG_POS_Y:   cfg_r.pos_y   <= cfg_data;
        REG_DIR_X:   cfg_r.dir_x   <= cfg_data[18:0];
        REG_DIR_Y:   cfg_r.dir_y   <= cfg_data[18:0];
        REG_PLANE_X: cfg_r.plane_x <= cfg_data[18:0];
        REG_PLANE_Y: cfg_r.plane_y <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

  grc_front #(
    .MAP_DIM (MAP_DIM)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_column     (in_column),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_cell_solid (in_cell_solid),
    .in_cell_red   (in_cell_red),
    .in_cell_green (in_cell_green),
    .in_cell_blue  (in_cell_blue),
    .stat          (stat),
    .q             (q)
  );

  grc_back #(
    .SCREEN_W  (SCREEN_W),
    .SCREEN_H  (SCREEN_H),
    .MAP_DIM   (MAP_DIM),
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .q     (q),
    .cfg   (cfg_r),
    .stat  (stat),
    .res   (res)
  );

  assign out_valid       = res.valid;
  assign out_column      = res.column;
  assign out_hit         = res.hit;
  assign out_wall_top    = res.wall_top;
  assign out_wall_bottom = res.wall_bottom;
  assign out_wall_color  = res.wall_color;
  assign out_hit_side    = res.hit_side;
  assign out_distance    = res.distance;

endmodule

`default_nettype wire

>>> bench/tb_grid_raycast_column.sv
// Self-checking bench for grid_raycast_column: drives map writes and column casts,
// predicts every cast result from a bench copy of the map and view registers.
// Depends on grc_pkg and the grid_raycast_column RTL.
`default_nettype none

module tb_grid_raycast_column;
  import grc_pkg::*;

  localparam int SCR_W = 320;
  localparam int SCR_H = 240;
  localparam int MAP_N = 64;
  localparam int STEP_LIMIT = 128;
  localparam int SETTLE_CYCLES = 500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam longint DELTA_NONE = 64'd1 << 40;

  typedef struct packed {
    op_t        op;
    logic [8:0] column;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       solid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic [8:0]  column;
    logic        hit;
    logic [7:0]  wall_top;
    logic [7:0]  wall_bottom;
    logic [31:0] wall_color;
    logic        hit_side;
    logic [23:0] distance;
  } column_res_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_func;
  logic [8:0]  in_column;
  logic [5:0]  in_cell_x;
  logic [5:0]  in_cell_y;
  logic        in_cell_solid;
  logic [7:0]  in_cell_red;
  logic [7:0]  in_cell_green;
  logic [7:0]  in_cell_blue;
  logic        out_valid;
  logic [8:0]  out_column;
  logic        out_hit;
  logic [7:0]  out_wall_top;
  logic [7:0]  out_wall_bottom;
  logic [31:0] out_wall_color;
  logic        out_hit_side;
  logic [23:0] out_distance;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [21:0] cfg_data;

  grid_raycast_column dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_column(in_column), .in_cell_x(in_cell_x),
    .in_cell_y(in_cell_y), .in_cell_solid(in_cell_solid),
    .in_cell_red(in_cell_red), .in_cell_green(in_cell_green),
    .in_cell_blue(in_cell_blue), .out_valid(out_valid), .out_column(out_column),
    .out_hit(out_hit), .out_wall_top(out_wall_top),
    .out_wall_bottom(out_wall_bottom), .out_wall_color(out_wall_color),
    .out_hit_side(out_hit_side), .out_distance(out_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // bench copy of the map and view registers
  logic [24:0]     map_cells [MAP_N*MAP_N];
  longint unsigned view_pos_x, view_pos_y;
  longint          view_dir_x, view_dir_y, view_plane_x, view_plane_y;

  cmd_t        pending_cmds[$];
  column_res_t expected_columns[$];
  int          mismatches = 0;
  int          idle_pct = 34;
  int          quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic longint sext19(logic [21:0] v);
    return longint'(signed'(v[18:0]));
  endfunction

  function automatic longint unsigned step_delta(longint r);
    longint unsigned a;
    a = (r < 0) ? longint'(-r) : longint'(r);
    if (a == 0) return DELTA_NONE;
    return (64'd1 << 32) / a;
  endfunction

  function automatic longint unsigned first_side(longint r, longint unsigned p,
                                                  longint unsigned d);
    longint unsigned f;
    f = p & 64'hFFFF;
    return (d * ((r < 0) ? f : (64'd65536 - f))) >> 16;
  endfunction

  function automatic column_res_t trace_column(logic [8:0] col);
    column_res_t     res;
    longint          cam, rx, ry, stx, sty, mx, my, half, top, bot;
    longint unsigned dx, dy, sx, sy, perp, line_h;
    logic            side, hit;
    logic [24:0]     hit_cell;
    int              r, g, b;
    cam = longint'((longint'(col) << 17) / SCR_W) - 65536;
    rx = view_dir_x + ((view_plane_x * cam) >>> 16);
    ry = view_dir_y + ((view_plane_y * cam) >>> 16);
    dx = step_delta(rx);
    dy = step_delta(ry);
    sx = first_side(rx, view_pos_x, dx);
    sy = first_side(ry, view_pos_y, dy);
    stx = (rx > 0) ? 1 : ((rx < 0) ? -1 : 0);
    sty = (ry > 0) ? 1 : ((ry < 0) ? -1 : 0);
    mx = longint'(view_pos_x >> 16);
    my = longint'(view_pos_y >> 16);
    side = 1'b0;
    hit = 1'b0;
    hit_cell = '0;
    for (int n = 0; n < STEP_LIMIT; n++) begin
      if (sx < sy) begin
        sx += dx;
        mx += stx;
        side = 1'b0;
      end else begin
        sy += dy;
        my += sty;
        side = 1'b1;
      end
      if (mx < 0 || my < 0 || mx >= MAP_N || my >= MAP_N) break;
      hit_cell = map_cells[mx*MAP_N + my];
      if (hit_cell[24]) begin
        hit = 1'b1;
        break;
      end
    end
    res.column = col;
    if (!hit) begin
      res.hit = 1'b0;
      res.wall_top = 8'(SCR_H / 2);
      res.wall_bottom = 8'(SCR_H / 2);
      res.wall_color = '0;
      res.hit_side = 1'b0;
      res.distance = 24'hFFFFFF;
      return res;
    end
    perp = side ? sy - dy : sx - dx;
    line_h = (longint'(SCR_H) << 16) / ((perp == 0) ? 1 : perp);
    half = longint'(line_h / 2);
    top = SCR_H / 2 - half;
    bot = SCR_H / 2 + half;
    if (top < 0) top = 0;
    if (bot > SCR_H - 1) bot = SCR_H - 1;
    r = hit_cell[23:16];
    g = hit_cell[15:8];
    b = hit_cell[7:0];
    if (side) begin
      r = r * 2 / 3;
      g = g * 2 / 3;
      b = b * 2 / 3;
    end
    res.hit = 1'b1;
    res.wall_top = 8'(top);
    res.wall_bottom = 8'(bot);
    res.wall_color = {8'hFF, 8'(r), 8'(g), 8'(b)};
    res.hit_side = side;
    res.distance = (perp > 64'hFFFFFF) ? 24'hFFFFFF : 24'(perp);
    return res;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [21:0] v);
    case (idx)
      REG_POS_X:   view_pos_x = v;
      REG_POS_Y:   view_pos_y = v;
      REG_DIR_X:   view_dir_x = sext19(v);
      REG_DIR_Y:   view_dir_y = sext19(v);
      REG_PLANE_X: view_plane_x = sext19(v);
      REG_PLANE_Y: view_plane_y = sext19(v);
      default: ;
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.op = op_t'($urandom_range(0, 1));
    c.column = 9'($urandom);
    c.cell_x = 6'($urandom);
    c.cell_y = 6'($urandom);
    c.solid = 1'($urandom);
    c.red = 8'($urandom);
    c.green = 8'($urandom);
    c.blue = 8'($urandom);
    return c;
  endfunction

  task automatic push_write(int x, int y, logic solid, logic [23:0] rgb);
    cmd_t c;
    c = random_cmd();
    c.op = OP_WRITE;
    c.cell_x = 6'(x);
    c.cell_y = 6'(y);
    c.solid = solid;
    {c.red, c.green, c.blue} = rgb;
    pending_cmds.push_back(c);
  endtask

  task automatic push_cast(int col);
    cmd_t c;
    c = random_cmd();
    c.op = OP_CAST;
    c.column = 9'(col);
    pending_cmds.push_back(c);
  endtask

  // called right after a rising edge; leaves cfg_valid high for a following write
  task automatic write_reg(logic [2:0] idx, logic [21:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, v);
  endtask

  task automatic write_view(longint px, longint py, longint ddx, longint ddy,
                            longint ppx, longint ppy);
    write_reg(REG_POS_X, 22'(px));
    write_reg(REG_POS_Y, 22'(py));
    write_reg(REG_DIR_X, {3'($urandom), 19'(ddx)});
    write_reg(REG_DIR_Y, {3'($urandom), 19'(ddy)});
    write_reg(REG_PLANE_X, {3'($urandom), 19'(ppx)});
    write_reg(REG_PLANE_Y, {3'($urandom), 19'(ppy)});
    cfg_valid <= 1'b0;
  endtask

  // hold until every queued command is done and every result has come back
  task automatic drain();
    while (pending_cmds.size() != 0 || expected_columns.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic longint pick_vec();
    case ($urandom_range(0, 7))
      0: return -131072;
      1: return 131072;
      2: return 0;
      3: return 65536;
      4: return -65536;
      default: return longint'($urandom_range(0, 262144)) - 131072;
    endcase
  endfunction

  function automatic longint pick_pos();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 22'h3FFFFF;
      2: return longint'($urandom_range(0, 63)) << 16;
      default: return $urandom_range(0, 22'h3FFFFF);
    endcase
  endfunction

  // driver: present the head of the pending queue, idling at random
  always @(posedge clk) begin
    cmd_t c;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        c = pending_cmds.pop_front();
        if (c.op == OP_WRITE)
          map_cells[c.cell_x*MAP_N + c.cell_y] = {c.solid, c.red, c.green, c.blue};
        else
          expected_columns.push_back(trace_column(c.column));
      end
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        c = pending_cmds[0];
        start <= 1'b1;
        in_func <= c.op;
        in_column <= c.column;
        in_cell_x <= c.cell_x;
        in_cell_y <= c.cell_y;
        in_cell_solid <= c.solid;
        in_cell_red <= c.red;
        in_cell_green <= c.green;
        in_cell_blue <= c.blue;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check each result strobe against the oldest prediction
  always @(posedge clk) begin
    column_res_t got, want;
    if (rst_n && out_valid) begin
      got = {out_column, out_hit, out_wall_top, out_wall_bottom, out_wall_color,
             out_hit_side, out_distance};
      if (expected_columns.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result for column %0d", out_column);
      end else begin
        want = expected_columns.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("col %0d: exp hit=%0d top=%0d bot=%0d color=%h side=%0d dist=%h | got col %0d hit=%0d top=%0d bot=%0d color=%h side=%0d dist=%h",
                     want.column, want.hit, want.wall_top, want.wall_bottom,
                     want.wall_color, want.hit_side, want.distance, got.column,
                     got.hit, got.wall_top, got.wall_bottom, got.wall_color,
                     got.hit_side, got.distance);
        end
      end
    end
  end

  // watchdog: count cycles in which no transfer of any kind happens
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("grid_raycast_column verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ncmd, px, py;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = 1'b0;
    in_column = '0;
    in_cell_x = '0;
    in_cell_y = '0;
    in_cell_solid = 1'b0;
    in_cell_red = '0;
    in_cell_green = '0;
    in_cell_blue = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (map_cells[i]) map_cells[i] = '0;
    view_pos_x = 0;
    view_pos_y = 0;
    view_dir_x = -65536;
    view_dir_y = 0;
    view_plane_x = 0;
    view_plane_y = 43254;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset view from the map corner: rays leave the map
    push_cast(0);
    push_cast(160);
    push_cast(319);
    push_cast(511);
    push_write(63, 63, 1'b1, 24'hFFFFFF);
    push_write(0, 0, 1'b1, 24'h000000);
    drain();

    // player on an x gridline facing -x: zero y ray, zero distance, y-side walls
    write_view(32'h200000, 32'h208000, -65536, 0, 0, 43254);
    push_write(31, 32, 1'b1, 24'hFF0080);
    for (int x = 28; x <= 35; x++) push_write(x, 28, 1'b1, 24'h80FF01);
    push_cast(160);
    push_cast(0);
    push_cast(319);
    push_cast(100);
    push_cast(400);
    push_write(31, 32, 1'b0, 24'h000000);
    push_cast(160);
    drain();

    // near-zero direction: distance saturates
    write_reg(REG_SPARE_A, 22'h3FFFFF);
    write_reg(REG_SPARE_B, 22'h155555);
    write_view(32'h200000, 32'h208000, 1, 0, 0, 0);
    push_write(33, 32, 1'b1, 24'h123456);
    push_cast(160);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      idle_pct = (phase == 3) ? 0 : 34;
      if (phase == 0)
        write_view(0, 22'h3FFFFF, 131072, -131072, -131072, 131072);
      else if (phase == 1)
        write_view(22'h3FFFFF, 0, -131072, 131072, 131072, -131072);
      else
        write_view(pick_pos(), pick_pos(), pick_vec(), pick_vec(), pick_vec(),
                   pick_vec());
      px = int'(view_pos_x >> 16);
      py = int'(view_pos_y >> 16);
      ncmd = 240;
      for (int k = 0; k < ncmd; k++) begin
        cmd_t c;
        c = random_cmd();
        if (c.op == OP_WRITE && $urandom_range(0, 1)) begin
          // cluster walls around the player so casts hit something
          c.cell_x = 6'((px + $urandom_range(0, 16) - 8) & 63);
          c.cell_y = 6'((py + $urandom_range(0, 16) - 8) & 63);
        end
        if (c.op == OP_CAST && $urandom_range(0, 9) != 0)
          c.column = 9'($urandom_range(0, SCR_W - 1));
        pending_cmds.push_back(c);
      end
      drain();
    end

    if (mismatches == 0)
      $display("grid_raycast_column verification clean");
    else
      $display("grid_raycast_column verification failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/core/grc_pkg.sv
rtl/core/grc_front.sv
rtl/core/grc_div.sv
rtl/core/grc_back.sv
rtl/core/grid_raycast_column.sv
bench/tb_grid_raycast_column.sv
